// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define VCLC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vclc assertion failed");

// condition that must never hold outside reset
`define VCLC_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("vclc forbidden condition seen");

`endif

// ----- src/vclc_pkg.sv -----
// shared types, constants and decode function of the vehicle command latch controller
`timescale 1ns / 1ps
`default_nettype none

package vclc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int POS_W  = 11;
    localparam int DUTY_W = 8;
    localparam int STEP_W = 4;

    localparam logic [POS_W-1:0] POS_MAX = 11'h7FF;

    // reset values of the configuration registers
    localparam logic [DUTY_W-1:0] DRIVE_DUTY_RST  = 8'd254;
    localparam logic [POS_W-1:0]  TILT_CENTER_RST = 11'd500;
    localparam logic [POS_W-1:0]  PAN_CENTER_RST  = 11'd700;
    localparam logic [POS_W-1:0]  TILT_MIN_RST    = 11'd400;
    localparam logic [POS_W-1:0]  TILT_MAX_RST    = 11'd900;
    localparam logic [POS_W-1:0]  PAN_MIN_RST     = 11'd50;
    localparam logic [POS_W-1:0]  PAN_MAX_RST     = 11'd1250;
    localparam logic [STEP_W-1:0] PAN_STEP_RST    = 4'd2;

    // servo positions after reset
    localparam logic [POS_W-1:0] TILT_POS_RST = 11'd500;
    localparam logic [POS_W-1:0] PAN_POS_RST  = 11'd700;

    // command characters
    localparam logic [7:0] CHAR_F = 8'h46;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_L = 8'h4C;
    localparam logic [7:0] CHAR_U = 8'h55;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_H = 8'h48;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_M = 8'h4D;

    typedef enum logic [3:0] {
        CMD_NONE = 4'd0,
        CMD_F    = 4'd1,
        CMD_B    = 4'd2,
        CMD_R    = 4'd3,
        CMD_L    = 4'd4,
        CMD_U    = 4'd5,
        CMD_D    = 4'd6,
        CMD_S    = 4'd7,
        CMD_H    = 4'd8
    } vclc_cmd_t;

    typedef enum logic [2:0] {
        REG_DRIVE_DUTY  = 3'd0,
        REG_TILT_CENTER = 3'd1,
        REG_PAN_CENTER  = 3'd2,
        REG_TILT_MIN    = 3'd3,
        REG_TILT_MAX    = 3'd4,
        REG_PAN_MIN     = 3'd5,
        REG_PAN_MAX     = 3'd6,
        REG_PAN_STEP    = 3'd7
    } vclc_reg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_duty;
        logic [POS_W-1:0]  tilt_center;
        logic [POS_W-1:0]  pan_center;
        logic [POS_W-1:0]  tilt_min;
        logic [POS_W-1:0]  tilt_max;
        logic [POS_W-1:0]  pan_min;
        logic [POS_W-1:0]  pan_max;
        logic [STEP_W-1:0] pan_step;
    } vclc_cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] drive_ch1;
        logic [DUTY_W-1:0] drive_ch2;
        logic [DUTY_W-1:0] drive_ch3;
        logic [DUTY_W-1:0] drive_ch4;
        logic [POS_W-1:0]  tilt_position;
        logic [POS_W-1:0]  pan_position;
        logic              fire_trigger;
        logic              sweep_trigger;
        logic [3:0]        held_command;
    } vclc_result_t;

    // map a command byte to its latch code, anything unknown is none
    function automatic vclc_cmd_t decode_cmd(input logic [7:0] b);
        vclc_cmd_t c;
        case (b)
            CHAR_F:  c = CMD_F;
            CHAR_B:  c = CMD_B;
            CHAR_R:  c = CMD_R;
            CHAR_L:  c = CMD_L;
            CHAR_U:  c = CMD_U;
            CHAR_D:  c = CMD_D;
            CHAR_S:  c = CMD_S;
            CHAR_H:  c = CMD_H;
            default: c = CMD_NONE;
        endcase
        return c;
    endfunction

    function automatic logic is_drive(input vclc_cmd_t c);
        return (c == CMD_F) || (c == CMD_B) || (c == CMD_R) || (c == CMD_L);
    endfunction

endpackage

`default_nettype wire

// ----- src/vclc_cmd_if.sv -----
// command channel interface: one command byte per transfer
`timescale 1ns / 1ps
`default_nettype none

interface vclc_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] command_byte;

    modport source (output valid, output command_byte, input ready);
    modport sink   (input valid, input command_byte, output ready);
endinterface

`default_nettype wire

// ----- src/vclc_res_if.sv -----
// result channel interface: motor duties, servo positions, triggers and latch
`timescale 1ns / 1ps
`default_nettype none

interface vclc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  drive_ch1;
    logic [7:0]  drive_ch2;
    logic [7:0]  drive_ch3;
    logic [7:0]  drive_ch4;
    logic [10:0] tilt_position;
    logic [10:0] pan_position;
    logic        fire_trigger;
    logic        sweep_trigger;
    logic [3:0]  held_command;

    modport source (
        output valid, output drive_ch1, output drive_ch2, output drive_ch3,
        output drive_ch4, output tilt_position, output pan_position,
        output fire_trigger, output sweep_trigger, output held_command,
        input ready
    );
    modport sink (
        input valid, input drive_ch1, input drive_ch2, input drive_ch3,
        input drive_ch4, input tilt_position, input pan_position,
        input fire_trigger, input sweep_trigger, input held_command,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/vclc_cfg.sv -----
// apb configuration register file
`timescale 1ns / 1ps
`default_nettype none

module vclc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vclc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vclc_pkg::DATA_W-1:0]   pwdata,
    output logic      [vclc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output vclc_pkg::vclc_cfg_t                cfg
);
    import vclc_pkg::*;

    vclc_cfg_t cfg_reg;
    vclc_reg_t reg_sel;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = vclc_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_duty  <= DRIVE_DUTY_RST;
            cfg_reg.tilt_center <= TILT_CENTER_RST;
            cfg_reg.pan_center  <= PAN_CENTER_RST;
            cfg_reg.tilt_min    <= TILT_MIN_RST;
            cfg_reg.tilt_max    <= TILT_MAX_RST;
            cfg_reg.pan_min     <= PAN_MIN_RST;
            cfg_reg.pan_max     <= PAN_MAX_RST;
            cfg_reg.pan_step    <= PAN_STEP_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_DRIVE_DUTY:  cfg_reg.drive_duty  <= pwdata[DUTY_W-1:0];
                REG_TILT_CENTER: cfg_reg.tilt_center <= pwdata[POS_W-1:0];
                REG_PAN_CENTER:  cfg_reg.pan_center  <= pwdata[POS_W-1:0];
                REG_TILT_MIN:    cfg_reg.tilt_min    <= pwdata[POS_W-1:0];
                REG_TILT_MAX:    cfg_reg.tilt_max    <= pwdata[POS_W-1:0];
                REG_PAN_MIN:     cfg_reg.pan_min     <= pwdata[POS_W-1:0];
                REG_PAN_MAX:     cfg_reg.pan_max     <= pwdata[POS_W-1:0];
                REG_PAN_STEP:    cfg_reg.pan_step    <= pwdata[STEP_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_DRIVE_DUTY:  prdata[DUTY_W-1:0] = cfg_reg.drive_duty;
            REG_TILT_CENTER: prdata[POS_W-1:0]  = cfg_reg.tilt_center;
            REG_PAN_CENTER:  prdata[POS_W-1:0]  = cfg_reg.pan_center;
            REG_TILT_MIN:    prdata[POS_W-1:0]  = cfg_reg.tilt_min;
            REG_TILT_MAX:    prdata[POS_W-1:0]  = cfg_reg.tilt_max;
            REG_PAN_MIN:     prdata[POS_W-1:0]  = cfg_reg.pan_min;
            REG_PAN_MAX:     prdata[POS_W-1:0]  = cfg_reg.pan_max;
            REG_PAN_STEP:    prdata[STEP_W-1:0] = cfg_reg.pan_step;
            default:         prdata             = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/vclc_core.sv -----
// command latch, servo positions and motor duty state with their next-state logic
`timescale 1ns / 1ps
`default_nettype none

module vclc_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [7:0]           command_byte,
    input  wire vclc_pkg::vclc_cfg_t  cfg,
    output vclc_pkg::vclc_result_t    result
);
    import vclc_pkg::*;

    vclc_cmd_t               latched_reg, latched_next;
    logic [POS_W-1:0]        tilt_reg, tilt_next;
    logic [POS_W-1:0]        pan_reg, pan_next;
    logic [3:0][DUTY_W-1:0]  duty_reg, duty_next;

    vclc_cmd_t               code;
    vclc_cmd_t               eff;
    logic                    is_fire;
    logic                    is_sweep;
    logic [POS_W:0]          pan_sum;
    logic [POS_W-1:0]        pan_up;
    logic [POS_W-1:0]        pan_dn;
    logic [POS_W-1:0]        step_ext;
    logic [DUTY_W-1:0]       duty;

    assign code     = decode_cmd(command_byte);
    assign is_fire  = (command_byte == CHAR_G);
    assign is_sweep = (command_byte == CHAR_M);
    assign eff      = (code != CMD_NONE) ? code : latched_reg;
    assign duty     = cfg.drive_duty;

    // pan step candidates, saturating at both ends of the range
    assign step_ext = {{(POS_W-STEP_W){1'b0}}, cfg.pan_step};
    assign pan_sum  = {1'b0, pan_reg} + {1'b0, step_ext};
    assign pan_up   = pan_sum[POS_W] ? POS_MAX : pan_sum[POS_W-1:0];
    assign pan_dn   = (pan_reg >= step_ext) ? (pan_reg - step_ext) : '0;

    // run the effective command, then toggle the latch; fire and sweep bytes leave all state unchanged
    always_comb
    begin
        latched_next = latched_reg;
        tilt_next    = tilt_reg;
        pan_next     = pan_reg;
        duty_next    = duty_reg;
        if (!is_fire && !is_sweep)
        begin
            case (eff)
                CMD_F:
                begin
                    tilt_next = cfg.tilt_center;
                    pan_next  = cfg.pan_center;
                    duty_next = {duty, 8'd0, duty, 8'd0};
                end
                CMD_B:
                begin
                    tilt_next = cfg.tilt_center;
                    pan_next  = cfg.pan_center;
                    duty_next = {8'd0, duty, 8'd0, duty};
                end
                CMD_R:
                begin
                    tilt_next = cfg.tilt_center;
                    pan_next  = cfg.pan_center;
                    duty_next = {8'd0, duty, duty, 8'd0};
                end
                CMD_L:
                begin
                    tilt_next = cfg.tilt_center;
                    pan_next  = cfg.pan_center;
                    duty_next = {duty, 8'd0, 8'd0, duty};
                end
                CMD_U:
                begin
                    duty_next = '0;
                    if (tilt_reg > cfg.tilt_min)
                        tilt_next = tilt_reg - POS_W'(1);
                end
                CMD_D:
                begin
                    duty_next = '0;
                    if (tilt_reg < cfg.tilt_max)
                        tilt_next = tilt_reg + POS_W'(1);
                end
                CMD_S:
                begin
                    duty_next = '0;
                    if (pan_reg < cfg.pan_max)
                        pan_next = pan_up;
                end
                CMD_H:
                begin
                    duty_next = '0;
                    if (pan_reg > cfg.pan_min)
                        pan_next = pan_dn;
                end
                default:
                begin
                    duty_next = duty_reg;
                end
            endcase

            if (code != CMD_NONE)
            begin
                if (latched_reg == code)
                begin
                    latched_next = CMD_NONE;
                    if (is_drive(code))
                        duty_next = '0;
                end
                else
                begin
                    latched_next = code;
                end
            end
        end
    end

    // state update on each transfer into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= CMD_NONE;
            tilt_reg    <= TILT_POS_RST;
            pan_reg     <= PAN_POS_RST;
            duty_reg    <= '0;
        end
        else if (advance)
        begin
            latched_reg <= latched_next;
            tilt_reg    <= tilt_next;
            pan_reg     <= pan_next;
            duty_reg    <= duty_next;
        end
    end

    // result of this tick
    always_comb
    begin
        result.drive_ch1     = duty_next[0];
        result.drive_ch2     = duty_next[1];
        result.drive_ch3     = duty_next[2];
        result.drive_ch4     = duty_next[3];
        result.tilt_position = tilt_next;
        result.pan_position  = pan_next;
        result.fire_trigger  = is_fire;
        result.sweep_trigger = is_sweep;
        result.held_command  = latched_next;
    end

endmodule

`default_nettype wire

// ----- src/vehicle_command_latch_controller_core.sv -----
// top level of the vehicle command latch controller
//
// One command byte is taken per clock cycle on cmd_in and one result per command
// comes out on res_out: the byte lands in the input register, the latch, servo
// and duty state is updated in a single pass of compares and adds, and the result
// is held in the output register until taken. Both stages advance together, so a
// command can be taken every cycle as long as res_out is drained; a stalled result
// stops intake only once both stages are full. The user must write configuration
// over the APB port only while no command is in flight; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module vehicle_command_latch_controller_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vclc_cmd_if.sink                           cmd_in,
    vclc_res_if.source                         res_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vclc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [vclc_pkg::DATA_W-1:0]   pwdata,
    output logic      [vclc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import vclc_pkg::*;

    vclc_cfg_t    cfg;
    vclc_result_t core_result;
    vclc_result_t res_reg;
    logic         cmd_valid_reg;
    logic [7:0]   cmd_byte_reg;
    logic         res_valid_reg;
    logic         advance;

    assign advance      = cmd_valid_reg && (!res_valid_reg || res_out.ready);
    assign cmd_in.ready = !cmd_valid_reg || advance;

    vclc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vclc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .command_byte (cmd_byte_reg),
        .cfg          (cfg),
        .result       (core_result)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd_in.ready)
        begin
            cmd_valid_reg <= cmd_in.valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (cmd_in.valid && cmd_in.ready)
        begin
            cmd_byte_reg <= cmd_in.command_byte;
        end
    end

    // output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign res_out.valid         = res_valid_reg;
    assign res_out.drive_ch1     = res_reg.drive_ch1;
    assign res_out.drive_ch2     = res_reg.drive_ch2;
    assign res_out.drive_ch3     = res_reg.drive_ch3;
    assign res_out.drive_ch4     = res_reg.drive_ch4;
    assign res_out.tilt_position = res_reg.tilt_position;
    assign res_out.pan_position  = res_reg.pan_position;
    assign res_out.fire_trigger  = res_reg.fire_trigger;
    assign res_out.sweep_trigger = res_reg.sweep_trigger;
    assign res_out.held_command  = res_reg.held_command;

endmodule

`default_nettype wire

// ----- src/vclc_checker.sv -----
// port-level assertions for the vehicle command latch controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module vclc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [7:0]  drive_ch1,
    input wire logic [7:0]  drive_ch2,
    input wire logic [7:0]  drive_ch3,
    input wire logic [7:0]  drive_ch4,
    input wire logic [10:0] tilt_position,
    input wire logic [10:0] pan_position,
    input wire logic        fire_trigger,
    input wire logic        sweep_trigger,
    input wire logic [3:0]  held_command
);
    import vclc_pkg::*;

    `include "assert_macros.svh"

    logic drive_off;
    logic servo_or_none;

    assign drive_off = (drive_ch1 == '0) && (drive_ch2 == '0)
                    && (drive_ch3 == '0) && (drive_ch4 == '0);
    assign servo_or_none = (held_command == CMD_NONE) || (held_command == CMD_U)
                        || (held_command == CMD_D) || (held_command == CMD_S)
                        || (held_command == CMD_H);

    // a motor never has both legs driven
    `VCLC_NEVER(a_no_shoot_through, clk, rst_n, res_valid && (((drive_ch1 != '0) && (drive_ch2 != '0)) || ((drive_ch3 != '0) && (drive_ch4 != '0))))

    // fire and sweep come from different bytes
    `VCLC_NEVER(a_single_trigger, clk, rst_n, res_valid && fire_trigger && sweep_trigger)

    // motors stay stopped unless a drive command is latched
    `VCLC_ASSERT(a_stop_when_not_driving, clk, rst_n, (res_valid && servo_or_none) |-> drive_off)

    // a stalled result holds
    `VCLC_ASSERT(a_stall_hold, clk, rst_n, (res_valid && !res_ready) |=> (res_valid && $stable(drive_ch1) && $stable(drive_ch2) && $stable(drive_ch3) && $stable(drive_ch4) && $stable(tilt_position) && $stable(pan_position) && $stable(held_command)))

endmodule

bind vehicle_command_latch_controller_core vclc_checker u_vclc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_out.valid),
    .res_ready     (res_out.ready),
    .drive_ch1     (res_out.drive_ch1),
    .drive_ch2     (res_out.drive_ch2),
    .drive_ch3     (res_out.drive_ch3),
    .drive_ch4     (res_out.drive_ch4),
    .tilt_position (res_out.tilt_position),
    .pan_position  (res_out.pan_position),
    .fire_trigger  (res_out.fire_trigger),
    .sweep_trigger (res_out.sweep_trigger),
    .held_command  (res_out.held_command)
);

`default_nettype wire
